@@ sv/hoc_pkg.sv @@
// hoc_pkg: shared constants, table entry types and control structs for the occurrence counter
`timescale 1ns / 1ps
`default_nettype none

package hoc_pkg;

    // table geometry
    localparam int unsigned NUM_BUCKETS     = 1024;
    localparam int unsigned WAYS_PER_BUCKET = 4;
    localparam int unsigned COUNT_WIDTH     = 16;

    // field widths
    localparam int unsigned KEY_W    = 31;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned OCOUNT_W = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned B_W      = $clog2(NUM_BUCKETS);
    localparam int unsigned WAY_W    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
    localparam int unsigned CMP_W    = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    // stream port widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned M_TUSER_W = 4;

    // first hash step: key mod HASH_MODULUS by reciprocal multiply
    localparam logic [63:0] HASH_MODULUS = 64'd999149;
    localparam int unsigned D_W   = $clog2(HASH_MODULUS + 64'd1);
    localparam logic [63:0] RECIP1 = (64'd1 << KEY_W) / HASH_MODULUS;
    localparam int unsigned M1_W  = $clog2(RECIP1 + 64'd1);
    localparam logic [63:0] Q1_MAX = ((64'd1 << KEY_W) - 64'd1) / HASH_MODULUS;
    localparam int unsigned Q1_W  = $clog2(Q1_MAX + 64'd1);
    localparam int unsigned P1_W  = KEY_W + M1_W;
    localparam int unsigned P2_W  = Q1_W + D_W;
    localparam int unsigned R_W   = $clog2(HASH_MODULUS);

    // second hash step: remainder mod NUM_BUCKETS by reciprocal multiply
    localparam logic [63:0] NB64   = 64'(NUM_BUCKETS);
    localparam logic [63:0] RECIP2 = (64'd1 << R_W) / NB64;
    localparam int unsigned M2_W  = $clog2(RECIP2 + 64'd1);
    localparam logic [63:0] Q2_MAX = (HASH_MODULUS - 64'd1) / NB64;
    localparam int unsigned Q2_W  = (Q2_MAX > 0) ? $clog2(Q2_MAX + 64'd1) : 1;
    localparam int unsigned NB_W  = $clog2(NB64 + 64'd1);
    localparam int unsigned P3_W  = R_W + M2_W;
    localparam int unsigned P4_W  = Q2_W + NB_W;

    // register stages from captured key to bucket index
    localparam int unsigned HASH_CYCLES = 6;
    localparam int unsigned HCNT_W      = $clog2(HASH_CYCLES);

    // request and status codes
    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    localparam logic [THR_W-1:0]       THRESHOLD_RESET = 16'd1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = {COUNT_WIDTH{1'b1}};

    // one way of a bucket, and one bucket row of the table memory
    typedef struct packed {
        logic                   valid;
        logic [KEY_W-1:0]       key;
        logic [COUNT_WIDTH-1:0] count;
    } entry_t;

    typedef entry_t [WAYS_PER_BUCKET-1:0] row_t;

    localparam int unsigned ROW_W = $bits(row_t);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_en;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/hash_occurrence_counter.sv @@
// hash_occurrence_counter: top level of the set-associative key occurrence counter
// an input beat passes the 6 hash stages, the table read and the update before its result beat
// one item in work at a time, the next input beat is taken only after the update (accept, hash, read, update)
// a waiting result beat does not hold off the next input beat
// reset: asynchronous, active low; afterwards a clearing pass over all 1024 bucket rows (one bucket
//   row a cycle) runs with s_axis_tready low, threshold writes are taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module hash_occurrence_counter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [hoc_pkg::THR_W-1:0]       cfg_wr_data,   // count_threshold
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [hoc_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // item_key[30:0]
    input  wire logic [hoc_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // req_type[0]
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [hoc_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // occurrence_count[15:0]
    output logic      [hoc_pkg::M_TUSER_W-1:0]   m_axis_tuser   // key_found[0],
                                                                // above_threshold[1],
                                                                // status_code[3:2]
);

    import hoc_pkg::*;

    dp_cmd_t             cmd;
    dp_sts_t             sts;
    logic                out_found;
    logic [OCOUNT_W-1:0] out_count;
    logic                out_above;
    logic [STATUS_W-1:0] out_status;

    // sequencer
    hoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // hashing, table and result
    hoc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_type     (s_axis_tuser[0]),
        .in_key      (s_axis_tdata[KEY_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_found   (out_found),
        .out_count   (out_count),
        .out_above   (out_above),
        .out_status  (out_status)
    );

    // result beat packing
    assign m_axis_tdata = out_count;
    assign m_axis_tuser = {out_status, out_above, out_found};

endmodule

`default_nettype wire

@@ sv/hoc_ram.sv @@
// hoc_ram: generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module hoc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/hoc_datapath.sv @@
// hoc_datapath: key hashing pipeline, bucket memory, way match and update, result register
`timescale 1ns / 1ps
`default_nettype none

module hoc_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire hoc_pkg::dp_cmd_t               cmd,
    output hoc_pkg::dp_sts_t                    sts,
    input  wire logic                           in_type,
    input  wire logic [hoc_pkg::KEY_W-1:0]      in_key,
    input  wire logic                           cfg_wr_en,
    input  wire logic [hoc_pkg::THR_W-1:0]      cfg_wr_data,
    output logic                                out_found,
    output logic      [hoc_pkg::OCOUNT_W-1:0]   out_count,
    output logic                                out_above,
    output logic      [hoc_pkg::STATUS_W-1:0]   out_status
);

    import hoc_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic [B_W-1:0]   clr_idx_reg;
    logic             type_reg;
    logic [KEY_W-1:0] key_reg;
    logic [P1_W-1:0]  prod1_reg;
    logic [P2_W-1:0]  prod2_reg;
    logic [R_W-1:0]   rmod_reg;
    logic [P3_W-1:0]  prod3_reg;
    logic [P4_W-1:0]  prod4_reg;
    logic [B_W-1:0]   bucket_reg;

    logic [Q1_W-1:0]  q1;
    logic [KEY_W-1:0] r_raw;
    logic [R_W-1:0]   rmod_next;
    logic [Q2_W-1:0]  q2;
    logic [R_W-1:0]   b_raw;
    logic [B_W-1:0]   bucket_next;

    logic [ROW_W-1:0] rd_data;
    row_t             row_rd;
    row_t             row_new;
    logic             ram_wr_en;
    logic [B_W-1:0]   ram_wr_addr;
    logic [ROW_W-1:0] ram_wr_data;

    logic                   hit;
    logic [WAY_W-1:0]       hit_idx;
    logic                   free;
    logic [WAY_W-1:0]       free_idx;
    logic [COUNT_WIDTH-1:0] hit_cnt;
    logic [COUNT_WIDTH-1:0] res_cnt;
    logic                   res_present;
    logic                   res_found;
    logic [STATUS_W-1:0]    res_status;
    logic                   res_above;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // clearing pass row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_idx_reg <= clr_idx_reg + B_W'(1);
        end
    end

    assign sts.clr_last = (clr_idx_reg == B_W'(NUM_BUCKETS - 1));

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= in_type;
            key_reg  <= in_key;
        end
    end

    // hash arithmetic between stages
    always_comb
    begin
        q1        = prod1_reg[KEY_W +: Q1_W];
        r_raw     = key_reg - KEY_W'(prod2_reg);
        rmod_next = (r_raw >= KEY_W'(HASH_MODULUS)) ? R_W'(r_raw - KEY_W'(HASH_MODULUS))
                                                    : R_W'(r_raw);
        q2        = prod3_reg[R_W +: Q2_W];
        b_raw     = rmod_reg - R_W'(prod4_reg);
        bucket_next = (b_raw >= R_W'(NUM_BUCKETS)) ? B_W'(b_raw - R_W'(NUM_BUCKETS))
                                                   : B_W'(b_raw);
    end

    // hash pipeline, settles from the captured key
    always_ff @(posedge clk)
    begin
        prod1_reg  <= P1_W'(key_reg) * P1_W'(RECIP1[M1_W-1:0]);
        prod2_reg  <= P2_W'(q1) * P2_W'(HASH_MODULUS[D_W-1:0]);
        rmod_reg   <= rmod_next;
        prod3_reg  <= P3_W'(rmod_reg) * P3_W'(RECIP2[M2_W-1:0]);
        prod4_reg  <= P4_W'(q2) * P4_W'(NB64[NB_W-1:0]);
        bucket_reg <= bucket_next;
    end

    // bucket memory, one row per bucket
    assign ram_wr_en   = cmd.clr_wr | (cmd.commit & (type_reg == REQ_COUNT));
    assign ram_wr_addr = cmd.clr_wr ? clr_idx_reg : bucket_reg;
    assign ram_wr_data = cmd.clr_wr ? '0 : ROW_W'(row_new);

    hoc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (bucket_reg),
        .rd_data (rd_data)
    );

    assign row_rd = row_t'(rd_data);

    // lowest matching way and lowest free way
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--)
        begin
            if (row_rd[w].valid && (row_rd[w].key == key_reg))
            begin
                hit     = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!row_rd[w].valid)
            begin
                free     = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    // row update and result
    always_comb
    begin
        row_new     = row_rd;
        hit_cnt     = row_rd[hit_idx].count;
        res_cnt     = '0;
        res_present = 1'b0;
        res_found   = 1'b0;
        res_status  = STATUS_OK;
        if (hit)
        begin
            res_found   = 1'b1;
            res_present = 1'b1;
            res_cnt     = hit_cnt;
            if (type_reg == REQ_COUNT)
            begin
                if (hit_cnt == COUNT_MAX)
                begin
                    res_status = STATUS_SAT;
                end
                else
                begin
                    res_cnt = hit_cnt + COUNT_WIDTH'(1);
                end
            end
            row_new[hit_idx].count = res_cnt;
        end
        else if (type_reg == REQ_QUERY)
        begin
            res_status = STATUS_OK;
        end
        else if (!free)
        begin
            res_status = STATUS_FULL;
        end
        else
        begin
            res_present             = 1'b1;
            res_cnt                 = COUNT_WIDTH'(1);
            row_new[free_idx].valid = 1'b1;
            row_new[free_idx].key   = key_reg;
            row_new[free_idx].count = COUNT_WIDTH'(1);
        end
        res_above = res_present && (CMP_W'(res_cnt) >= CMP_W'(thr_reg));
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_found  <= res_found;
            out_count  <= OCOUNT_W'(res_cnt);
            out_above  <= res_above;
            out_status <= res_status;
        end
    end

endmodule

`default_nettype wire

@@ sv/hoc_ctrl.sv @@
// hoc_ctrl: sequencer for the clearing pass, hashing wait, bucket read and update
`timescale 1ns / 1ps
`default_nettype none

module hoc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hoc_pkg::dp_cmd_t      cmd,
    input  wire hoc_pkg::dp_sts_t sts
);

    import hoc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_EVAL
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [HCNT_W-1:0] cnt_reg;
    logic [HCNT_W-1:0] cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // commands decoded from state
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.clr_wr = (state_reg == S_CLEAR);
    assign cmd.rd_en  = (state_reg == S_READ);
    assign cmd.commit = (state_reg == S_EVAL) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                    cnt_next   = '0;
                end
            end
            S_HASH:
            begin
                if (cnt_reg == HCNT_W'(HASH_CYCLES - 1))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cnt_next = cnt_reg + HCNT_W'(1);
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hoc_checker.sv @@
// hoc_checker: port-level assertions for the occurrence counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hoc_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [hoc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [hoc_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    import hoc_pkg::*;

    logic       s_beat;
    logic       m_beat;
    logic [1:0] pending_reg;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_axis_tvalid && m_axis_tready;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, s_beat} - {1'b0, m_beat};
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // no result without an accepted item, never more than two outstanding
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || (pending_reg != 2'd0)) && (pending_reg != 2'd3))
        else $error("result beats do not match accepted input beats");

    // full bucket reports an absent key
    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[3:2] == STATUS_FULL) |->
            (m_axis_tdata == '0) && (m_axis_tuser[1:0] == 2'b00))
        else $error("full bucket result carries a count or a found flag");

    // saturated count reports a found key at all ones
    a_sat_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[3:2] == STATUS_SAT) |->
            m_axis_tuser[0] && (m_axis_tdata == M_TDATA_W'(COUNT_MAX)))
        else $error("saturated result without found key or maximum count");

endmodule

bind hash_occurrence_counter hoc_checker u_hoc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/hash_occurrence_counter_tb.sv @@
// hash_occurrence_counter_tb: stream testbench, directed table and random bursts vs a predictor
`timescale 1ns / 1ps

module hash_occurrence_counter_tb;
    import hoc_pkg::*;

    localparam int unsigned TABLE_DEPTH  = NUM_BUCKETS * WAYS_PER_BUCKET;
    localparam int unsigned PIPE_CYCLES  = 12;
    localparam int unsigned BURST_ITEMS  = 250;
    localparam int          STEADY_ITEMS = 200;
    localparam longint      RUN_LIMIT_NS = 64'd8_000_000;

    // one result beat, unpacked from tdata and tuser
    typedef struct packed {
        logic                found;
        logic [OCOUNT_W-1:0] count;
        logic                above;
        logic [STATUS_W-1:0] status;
    } tally_t;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic             req;
        logic [KEY_W-1:0] key;
        logic             typed;
        tally_t           want;
    } stim_row_t;

    localparam tally_t T_ABSENT = '{1'b0, 16'd0, 1'b0, STATUS_OK};
    localparam tally_t T_NEW    = '{1'b0, 16'd1, 1'b1, STATUS_OK};
    localparam tally_t T_TWO    = '{1'b1, 16'd2, 1'b1, STATUS_OK};
    localparam tally_t T_FULL   = '{1'b0, 16'd0, 1'b0, STATUS_FULL};
    localparam tally_t T_ANY    = '0;

    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};
    localparam int unsigned      N_ROWS  = 21;

    // keys 5, 1029, 2053, 3077, 4101 and 999154 all share bucket 5
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{REQ_QUERY, 31'd0,          1'b1, T_ABSENT},
        '{REQ_COUNT, 31'd0,          1'b1, T_NEW},
        '{REQ_COUNT, 31'd0,          1'b1, T_TWO},
        '{REQ_QUERY, 31'd0,          1'b1, T_TWO},
        '{REQ_QUERY, KEY_TOP,        1'b1, T_ABSENT},
        '{REQ_COUNT, KEY_TOP,        1'b1, T_NEW},
        '{REQ_QUERY, KEY_TOP,        1'b0, T_ANY},
        '{REQ_COUNT, 31'd999149,     1'b1, T_NEW},
        '{REQ_QUERY, 31'd999149,     1'b0, T_ANY},
        '{REQ_COUNT, 31'd5,          1'b1, T_NEW},
        '{REQ_COUNT, 31'd1029,       1'b1, T_NEW},
        '{REQ_COUNT, 31'd2053,       1'b1, T_NEW},
        '{REQ_COUNT, 31'd3077,       1'b1, T_NEW},
        '{REQ_COUNT, 31'd4101,       1'b1, T_FULL},
        '{REQ_COUNT, 31'd999154,     1'b1, T_FULL},
        '{REQ_QUERY, 31'd4101,       1'b1, T_ABSENT},
        '{REQ_COUNT, 31'd3077,       1'b0, T_ANY},
        '{REQ_QUERY, 31'd5,          1'b0, T_ANY},
        '{REQ_COUNT, 31'h5555_5555,  1'b0, T_ANY},
        '{REQ_COUNT, 31'h2AAA_AAAA,  1'b0, T_ANY},
        '{REQ_QUERY, 31'h5555_5555,  1'b0, T_ANY}
    };

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [THR_W-1:0]     cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // predictor state: shadow of the bucket table and the threshold register
    logic                   shadow_valid [TABLE_DEPTH];
    logic [KEY_W-1:0]       shadow_key   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] shadow_count [TABLE_DEPTH];
    logic [THR_W-1:0]       shadow_threshold = THRESHOLD_RESET;

    tally_t      pending_tallies [$];
    logic [KEY_W-1:0] hot_keys   [$];
    int unsigned mismatch_count = 0;
    logic        steady_flow    = 1'b0;

    hash_occurrence_counter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop for a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[hash_occurrence_counter] ERROR");
        $finish;
    end

    // look up the key in the shadow table, apply the request, return the result beat
    function automatic tally_t tally_lookup(input logic req, input logic [KEY_W-1:0] key);
        int unsigned base;
        int          hit;
        int          free_way;
        int unsigned idx;
        tally_t      res;
        base     = int'((64'(key) % HASH_MODULUS) % NUM_BUCKETS) * WAYS_PER_BUCKET;
        hit      = -1;
        free_way = -1;
        res      = '0;
        for (int w = 0; w < WAYS_PER_BUCKET; w++)
        begin
            if (shadow_valid[base + w])
            begin
                if (hit < 0 && shadow_key[base + w] == key)
                    hit = w;
            end
            else if (free_way < 0)
                free_way = w;
        end
        if (hit >= 0)
        begin
            idx        = base + hit;
            res.status = STATUS_OK;
            if (req == REQ_COUNT)
            begin
                if (shadow_count[idx] == COUNT_MAX)
                    res.status = STATUS_SAT;
                else
                    shadow_count[idx] = shadow_count[idx] + 1'b1;
            end
            res.found = 1'b1;
            res.count = OCOUNT_W'(shadow_count[idx]);
            res.above = (CMP_W'(shadow_count[idx]) >= CMP_W'(shadow_threshold));
        end
        else if (req == REQ_QUERY)
            res = '{1'b0, 16'd0, 1'b0, STATUS_OK};
        else if (free_way < 0)
            res = '{1'b0, 16'd0, 1'b0, STATUS_FULL};
        else
        begin
            idx               = base + free_way;
            shadow_valid[idx] = 1'b1;
            shadow_key[idx]   = key;
            shadow_count[idx] = 1;
            res = '{1'b0, 16'd1, (CMP_W'(1) >= CMP_W'(shadow_threshold)), STATUS_OK};
        end
        return res;
    endfunction

    // drive one request beat; the expectation is queued at the accepting edge
    task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
                                input logic typed, input tally_t want);
        tally_t predicted;
        while (!steady_flow && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - KEY_W){1'b0}}, key};
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = tally_lookup(req, key);
        pending_tallies.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // hold the sender until every queued result has been seen
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_tallies.size() != 0);
    endtask

    // threshold write, only with the block idle
    task automatic write_threshold(input logic [THR_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en        <= 1'b0;
        shadow_threshold  = value;
    endtask

    // random requests, mostly on a few crowded buckets so ways fill and overflow
    task automatic random_burst(input int unsigned n_items);
        logic [KEY_W-1:0] key;
        int unsigned      b;
        logic             req;
        hot_keys.delete();
        for (int g = 0; g < 2; g++)
        begin
            b = $urandom_range(NUM_BUCKETS - 1);
            for (int j = 0; j < 6; j++)
                hot_keys.push_back(KEY_W'(b + NUM_BUCKETS * $urandom_range(7)
                                   + 999149 * $urandom_range(2148)));
        end
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < 85)
                key = hot_keys[$urandom_range(hot_keys.size() - 1)];
            else
                key = KEY_W'($urandom());
            req = ($urandom_range(99) < 60) ? REQ_COUNT : REQ_QUERY;
            if ($urandom_range(199) == 0)
                drain_results();
            send_request(req, key, 1'b0, T_ANY);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        tally_t got;
        tally_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.found  = m_axis_tuser[0];
            got.above  = m_axis_tuser[1];
            got.status = m_axis_tuser[3:2];
            got.count  = m_axis_tdata;
            if (pending_tallies.size() == 0)
            begin
                $error("unexpected result beat: tdata %0d tuser %0d", m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                if (got.found !== want.found)
                begin
                    $error("key_found: expected %0d, got %0d", want.found, got.found);
                    mismatch_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("occurrence_count: expected %0d, got %0d", want.count, got.count);
                    mismatch_count++;
                end
                if (got.above !== want.above)
                begin
                    $error("above_threshold: expected %0d, got %0d", want.above, got.above);
                    mismatch_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status_code: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge clk)
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 26);

    // main sequence
    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_count[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at the reset threshold
        for (int r = 0; r < N_ROWS; r++)
            send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].key,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // count the top key over and over, no idling on either side
        write_threshold(16'hFFFF);
        steady_flow = 1'b1;
        for (int i = 0; i < STEADY_ITEMS; i++)
            send_request(REQ_COUNT, KEY_TOP, 1'b0, T_ANY);
        send_request(REQ_QUERY, KEY_TOP, 1'b0, T_ANY);
        steady_flow = 1'b0;

        // random bursts across threshold settings
        write_threshold(16'd0);
        random_burst(BURST_ITEMS);
        write_threshold(16'd2);
        random_burst(BURST_ITEMS);
        write_threshold(THR_W'($urandom_range(3, 6)));
        random_burst(BURST_ITEMS);
        write_threshold(16'hFFFF);
        random_burst(BURST_ITEMS);
        write_threshold(THRESHOLD_RESET);
        random_burst(BURST_ITEMS);

        drain_results();
        repeat (PIPE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[hash_occurrence_counter] OK");
        else
            $display("[hash_occurrence_counter] ERROR");
        $finish;
    end

endmodule
